>>> hdl/assert_macros.svh
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define HCB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("huffman check failed");

// next-cycle implication, sampled on clk, off during reset
`define HCB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("huffman check failed");

`endif

>>> hdl/hcb_pkg.sv
`default_nettype none
package hcb_pkg;

    localparam int CODE_W  = 25;
    localparam int LEN_W   = 5;
    localparam int WGT_W   = 7;
    localparam int LTR_W   = 5;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic init_start;
        logic init_step;
        logic scan_start;
        logic scan_step;
        logic take_a;
        logic take_b;
        logic merge0;
        logic merge1;
        logic cp_start;
        logic cp_a;
        logic cp_b;
        logic cp_c;
        logic em_start;
        logic em_a;
        logic em_b;
        logic em_c;
        logic finish;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic line_nonempty;
        logic init_last;
        logic scan_last;
        logic more_merge;
        logic cp_last;
        logic em_last;
        logic out_taken;
    } stat_t;

endpackage
`default_nettype wire

>>> hdl/hcb_ctrl.sv
`default_nettype none
module hcb_ctrl
    import hcb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  letter_valid,
    input  wire logic  last,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [14:0] {
        S_LOAD  = 15'b000000000000001,
        S_INIT  = 15'b000000000000010,
        S_CHK   = 15'b000000000000100,
        S_SCAN1 = 15'b000000000001000,
        S_TAKE1 = 15'b000000000010000,
        S_SCAN2 = 15'b000000000100000,
        S_TAKE2 = 15'b000000001000000,
        S_MRG0  = 15'b000000010000000,
        S_MRG1  = 15'b000000100000000,
        S_CPS   = 15'b000001000000000,
        S_CPA   = 15'b000010000000000,
        S_CPB   = 15'b000100000000000,
        S_CPC   = 15'b001000000000000,
        S_EMA   = 15'b010000000000000,
        S_EMW   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   em_ph_reg, em_ph_next;  // emission sub-phase: 0 line read, 1 code read
    logic   em_c_reg, em_c_next;    // output load cycle

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            em_ph_reg <= 1'b0;
            em_c_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            em_ph_reg <= em_ph_next;
            em_c_reg  <= em_c_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        em_ph_next = em_ph_reg;
        em_c_next  = em_c_reg;
        cmd        = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load = 1'b1;
                if (letter_valid && last && stat.line_nonempty)
                begin
                    cmd.init_start = 1'b1;
                    state_next     = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_last)
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.more_merge)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN1;
                end
                else
                    state_next = S_CPS;
            end
            S_SCAN1:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_TAKE1;
            end
            S_TAKE1:
            begin
                cmd.take_a     = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN2;
            end
            S_SCAN2:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                    state_next = S_TAKE2;
            end
            S_TAKE2:
            begin
                cmd.take_b = 1'b1;
                state_next = S_MRG0;
            end
            S_MRG0:
            begin
                cmd.merge0 = 1'b1;
                state_next = S_MRG1;
            end
            S_MRG1:
            begin
                cmd.merge1 = 1'b1;
                state_next = S_CHK;
            end
            S_CPS:
            begin
                cmd.cp_start = 1'b1;
                state_next   = S_CPA;
            end
            S_CPA:
            begin
                cmd.cp_a   = 1'b1;
                state_next = S_CPB;
            end
            S_CPB:
            begin
                cmd.cp_b   = 1'b1;
                state_next = S_CPC;
            end
            S_CPC:
            begin
                cmd.cp_c = 1'b1;
                if (stat.cp_last)
                begin
                    cmd.em_start = 1'b1;
                    em_ph_next   = 1'b0;
                    state_next   = S_EMA;
                end
                else
                    state_next = S_CPA;
            end
            S_EMA:
            begin
                // line read, then code read, then output load
                if (em_c_reg)
                begin
                    cmd.em_c   = 1'b1;
                    em_c_next  = 1'b0;
                    state_next = S_EMW;
                end
                else if (!em_ph_reg)
                begin
                    cmd.em_a   = 1'b1;
                    em_ph_next = 1'b1;
                end
                else
                begin
                    cmd.em_b   = 1'b1;
                    em_ph_next = 1'b0;
                    em_c_next  = 1'b1;
                end
            end
            S_EMW:
            begin
                if (stat.out_taken)
                begin
                    if (stat.em_last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                        state_next = S_EMA;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/hcb_datapath.sv
`default_nettype none
module hcb_datapath
    import hcb_pkg::*;
#(
    parameter int LINE_MAX = 64,
    parameter int ALPHABET = 26
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cmd_t               cmd,
    output stat_t                   stat,
    input  wire logic               letter_valid,
    input  wire logic [LTR_W-1:0]   letter,
    output logic                    code_valid,
    input  wire logic               code_stall,
    output logic [LTR_W-1:0]        out_letter,
    output logic [CODE_W-1:0]       code_bits,
    output logic [LEN_W-1:0]        code_length,
    output logic                    end_of_line
);

    localparam int NODES = 2 * ALPHABET - 1;
    localparam int NI    = $clog2(NODES);
    localparam int NW    = $clog2(NODES + 1);
    localparam int LB    = $clog2(ALPHABET);
    localparam int LA    = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int LCW   = $clog2(LINE_MAX + 1);
    localparam int CE_W  = LEN_W + CODE_W;

    // memories
    logic [LTR_W-1:0] line_mem [LINE_MAX];
    logic [WGT_W-1:0] wgt_mem  [NODES];
    logic [NI:0]      par_mem  [NODES];   // parent index and branch bit
    logic [CE_W-1:0]  code_mem [NODES];   // length and code bits

    // flop arrays cleared at once
    logic [WGT_W-1:0] cnt_reg [ALPHABET];
    logic [NODES-1:0] active_reg;
    logic [NODES-1:0] haspar_reg;

    logic [LCW-1:0]   line_cnt_reg;
    logic [LCW-1:0]   pos_reg;
    logic [NW-1:0]    idx_reg;
    logic [NW-1:0]    idx_d_reg;
    logic             pv_reg;
    logic [NW-1:0]    next_reg;
    logic [NW-1:0]    nact_reg;
    logic             best_v_reg;
    logic [WGT_W-1:0] best_w_reg;
    logic [NI-1:0]    best_i_reg;
    logic [NI-1:0]    a_reg, b_reg;
    logic [WGT_W-1:0] wa_reg, wb_reg;
    logic [WGT_W-1:0] w_rd_reg;
    logic [NI:0]      p_rd_reg;
    logic             hp_reg;
    logic [CE_W-1:0]  c_rd_reg;
    logic [LTR_W-1:0] l_rd_reg;
    logic             ovalid_reg;

    logic             ltr_ok;
    logic             store_ok;
    logic             in_fire;
    logic [WGT_W-1:0] init_cnt;
    logic [LEN_W-1:0] new_len;
    logic [CODE_W-1:0] new_bits;

    assign ltr_ok   = (letter < LTR_W'(ALPHABET));
    assign store_ok = ltr_ok && (line_cnt_reg < LCW'(LINE_MAX));
    assign in_fire  = cmd.load && letter_valid;
    assign init_cnt = cnt_reg[idx_reg[LB-1:0]];

    // status
    assign stat.line_nonempty = (line_cnt_reg != '0) || store_ok;
    assign stat.init_last     = (idx_reg == NW'(ALPHABET - 1));
    assign stat.scan_last     = (idx_reg == next_reg);
    assign stat.more_merge    = (nact_reg > NW'(1));
    assign stat.cp_last       = (idx_reg == '0);
    assign stat.em_last       = end_of_line;
    assign stat.out_taken     = ovalid_reg && !code_stall;

    // child code from parent code
    assign new_len  = c_rd_reg[CE_W-1:CODE_W] + LEN_W'(1);
    assign new_bits = {c_rd_reg[CODE_W-2:0], p_rd_reg[0]};

    // line store
    always_ff @(posedge clk)
    begin
        if (in_fire && store_ok)
            line_mem[line_cnt_reg[LA-1:0]] <= letter;
        if (cmd.em_a)
            l_rd_reg <= line_mem[pos_reg[LA-1:0]];
    end

    // weight memory
    always_ff @(posedge clk)
    begin
        if (cmd.init_step && init_cnt != '0)
            wgt_mem[idx_reg[NI-1:0]] <= init_cnt;
        else if (cmd.merge0)
            wgt_mem[next_reg[NI-1:0]] <= wa_reg + wb_reg;
        if (cmd.scan_step)
            w_rd_reg <= wgt_mem[idx_reg[NI-1:0]];
    end

    // parent memory
    always_ff @(posedge clk)
    begin
        if (cmd.merge0)
            par_mem[a_reg] <= {next_reg[NI-1:0], 1'b0};
        else if (cmd.merge1)
            par_mem[b_reg] <= {next_reg[NI-1:0], 1'b1};
        if (cmd.cp_a)
        begin
            p_rd_reg <= par_mem[idx_reg[NI-1:0]];
            hp_reg   <= haspar_reg[idx_reg[NI-1:0]];
        end
    end

    // code memory
    always_ff @(posedge clk)
    begin
        if (cmd.cp_c)
            code_mem[idx_reg[NI-1:0]] <= hp_reg ? {new_len, new_bits} : '0;
        if (cmd.cp_b)
            c_rd_reg <= code_mem[p_rd_reg[NI:1]];
        else if (cmd.em_b)
            c_rd_reg <= code_mem[NI'(l_rd_reg)];
    end

    // letter counts and line length
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ALPHABET; i++)
                cnt_reg[i] <= '0;
            line_cnt_reg <= '0;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < ALPHABET; i++)
                cnt_reg[i] <= '0;
            line_cnt_reg <= '0;
        end
        else if (in_fire && store_ok)
        begin
            cnt_reg[letter[LB-1:0]] <= cnt_reg[letter[LB-1:0]] + WGT_W'(1);
            line_cnt_reg <= line_cnt_reg + LCW'(1);
        end
    end

    // tree build control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            idx_d_reg  <= '0;
            pv_reg     <= 1'b0;
            next_reg   <= '0;
            nact_reg   <= '0;
            best_v_reg <= 1'b0;
            active_reg <= '0;
            haspar_reg <= '0;
        end
        else
        begin
            if (cmd.init_start)
            begin
                idx_reg    <= '0;
                active_reg <= '0;
                haspar_reg <= '0;
                next_reg   <= NW'(ALPHABET);
                nact_reg   <= '0;
            end
            if (cmd.init_step)
            begin
                if (init_cnt != '0)
                begin
                    active_reg[idx_reg[NI-1:0]] <= 1'b1;
                    nact_reg <= nact_reg + NW'(1);
                end
                idx_reg <= idx_reg + NW'(1);
            end
            if (cmd.scan_start)
            begin
                idx_reg    <= '0;
                pv_reg     <= 1'b0;
                best_v_reg <= 1'b0;
            end
            // serial minimum search, ties go to the lower index
            if (cmd.scan_step)
            begin
                idx_reg   <= idx_reg + NW'(1);
                idx_d_reg <= idx_reg;
                pv_reg    <= (idx_reg < next_reg);
                if (pv_reg && active_reg[idx_d_reg[NI-1:0]] &&
                    (!best_v_reg || w_rd_reg < best_w_reg))
                begin
                    best_v_reg <= 1'b1;
                    best_w_reg <= w_rd_reg;
                    best_i_reg <= idx_d_reg[NI-1:0];
                end
            end
            if (cmd.take_a)
            begin
                a_reg  <= best_i_reg;
                wa_reg <= best_w_reg;
                active_reg[best_i_reg] <= 1'b0;
            end
            if (cmd.take_b)
            begin
                b_reg  <= best_i_reg;
                wb_reg <= best_w_reg;
                active_reg[best_i_reg] <= 1'b0;
            end
            if (cmd.merge0)
            begin
                haspar_reg[a_reg] <= 1'b1;
                active_reg[next_reg[NI-1:0]] <= 1'b1;
            end
            if (cmd.merge1)
            begin
                haspar_reg[b_reg] <= 1'b1;
                next_reg <= next_reg + NW'(1);
                nact_reg <= nact_reg - NW'(1);
            end
            // code pass walks nodes downward, parents first
            if (cmd.cp_start)
                idx_reg <= next_reg - NW'(1);
            if (cmd.cp_c)
                idx_reg <= idx_reg - NW'(1);
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            if (cmd.em_start)
                pos_reg <= '0;
            if (cmd.em_c)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && !code_stall)
            begin
                ovalid_reg <= 1'b0;
                pos_reg    <= pos_reg + LCW'(1);
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.em_c)
        begin
            out_letter  <= l_rd_reg;
            code_bits   <= c_rd_reg[CODE_W-1:0];
            code_length <= c_rd_reg[CE_W-1:CODE_W];
            end_of_line <= (pos_reg == line_cnt_reg - LCW'(1));
        end
    end

    assign code_valid = ovalid_reg;

endmodule
`default_nettype wire

>>> hdl/huffman_code_builder.sv
// huffman_code_builder: builds a Huffman code for one line of lowercase letters.
// Letter channel (letter_valid/letter_stall, fields letter, last): one word per
// cycle while loading; letters 26 and up are ignored, lines over LINE_MAX
// letters saturate. The word marked last closes the line; an empty line gives
// nothing. After a non-empty line the letter channel stalls while the tree is
// built: a setup pass over the letter counts, then per merge a check, two serial
// minimum scans over the nodes so far (serial because of the single weight
// memory read port) and take and merge steps, then a final check, a start step
// and a code pass that, per node, reads the parent and the parent's code.
// Code channel (code_valid/code_stall, fields out_letter, code_bits,
// code_length, end_of_line): one word per stored letter, in line order. Each
// word goes through line read, code read and output load and is then offered
// until the receiver takes it; the next word starts only after that. A stalled
// word holds steady. end_of_line marks the final word, after which loading
// resumes. Reset (rst_n, async, low) empties the line and counts.
`default_nettype none
module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int LINE_MAX = 64,
    parameter int ALPHABET = 26
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              letter_valid,
    output logic                   letter_stall,
    input  wire logic [LTR_W-1:0]  letter,
    input  wire logic              last,
    output logic                   code_valid,
    input  wire logic              code_stall,
    output logic [LTR_W-1:0]       out_letter,
    output logic [CODE_W-1:0]      code_bits,
    output logic [LEN_W-1:0]       code_length,
    output logic                   end_of_line
);

    cmd_t  cmd;
    stat_t stat;

    assign letter_stall = !cmd.load;

    // sequencer
    hcb_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_valid (letter_valid),
        .last         (last),
        .stat         (stat),
        .cmd          (cmd)
    );

    // storage and arithmetic
    hcb_datapath #(
        .LINE_MAX (LINE_MAX),
        .ALPHABET (ALPHABET)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .letter_valid (letter_valid),
        .letter       (letter),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .out_letter   (out_letter),
        .code_bits    (code_bits),
        .code_length  (code_length),
        .end_of_line  (end_of_line)
    );

endmodule
`default_nettype wire

>>> hdl/hcb_checker.sv
`default_nettype none
`include "assert_macros.svh"
module hcb_checker
    import hcb_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              letter_stall,
    input wire logic              code_valid,
    input wire logic              code_stall,
    input wire logic [CODE_W-1:0] code_bits,
    input wire logic [LEN_W-1:0]  code_length
);

    // a stalled code word stays offered
    `HCB_ASSERT_NXT(a_hold, code_valid && code_stall, code_valid)
    // letters are not taken while codes go out
    `HCB_ASSERT_IMP(a_no_load, code_valid, letter_stall)
    // an empty code carries no bits
    `HCB_ASSERT_IMP(a_empty, code_valid && code_length == '0, code_bits == '0)
    // code length stays within the alphabet depth
    `HCB_ASSERT_IMP(a_len, code_valid, code_length < LEN_W'(26))

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .letter_stall (letter_stall),
    .code_valid   (code_valid),
    .code_stall   (code_stall),
    .code_bits    (code_bits),
    .code_length  (code_length)
);
`default_nettype wire

>>> tb/huffman_code_builder_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module huffman_code_builder_tb;
    import hcb_pkg::*;

    localparam int LINE_MAX = 64;
    localparam int ALPHABET = 26;
    localparam int NODES    = 2 * ALPHABET - 1;

    typedef struct packed {
        logic [LTR_W-1:0]  ltr;
        logic [CODE_W-1:0] bits;
        logic [LEN_W-1:0]  len;
        logic              eol;
    } code_word_t;

    // scoreboard: tracks the open line and the queue of expected code words
    class code_scoreboard;
        logic [LTR_W-1:0] line_ltrs[$];
        logic [6:0]       freq[ALPHABET];
        code_word_t       pending[$];
        int               errors;

        function new();
            errors = 0;
            foreach (freq[i]) freq[i] = '0;
        endfunction

        // derive the code table from the letter counts
        function void build_table(output logic [CODE_W-1:0] cb[ALPHABET],
                                  output logic [LEN_W-1:0] cl[ALPHABET]);
            logic [6:0]        wgt[NODES];
            int                kid0[NODES];
            int                kid1[NODES];
            int                act[$];
            logic [CODE_W-1:0] nc[NODES];
            logic [LEN_W-1:0]  nl[NODES];
            int                nxt;
            int                pick[2];
            int                best;
            nxt = ALPHABET;
            for (int n = 0; n < NODES; n++)
            begin
                nc[n] = '0;
                nl[n] = '0;
            end
            for (int s = 0; s < ALPHABET; s++)
                if (freq[s] != 0)
                begin
                    wgt[s] = freq[s];
                    act.push_back(s);
                end
            // merge two least nodes, ties broken by lower node index
            while (act.size() > 1 && nxt < NODES)
            begin
                for (int t = 0; t < 2; t++)
                begin
                    best = 0;
                    for (int i = 1; i < act.size(); i++)
                        if (wgt[act[i]] < wgt[act[best]] ||
                            (wgt[act[i]] == wgt[act[best]] && act[i] < act[best]))
                            best = i;
                    pick[t] = act[best];
                    act[best] = act[act.size()-1];
                    void'(act.pop_back());
                end
                wgt[nxt] = wgt[pick[0]] + wgt[pick[1]];
                kid0[nxt] = pick[0];
                kid1[nxt] = pick[1];
                act.push_back(nxt);
                nxt++;
            end
            // walk merged nodes top down
            for (int p = nxt - 1; p >= ALPHABET; p--)
            begin
                nc[kid0[p]] = {nc[p][CODE_W-2:0], 1'b0};
                nl[kid0[p]] = nl[p] + LEN_W'(1);
                nc[kid1[p]] = {nc[p][CODE_W-2:0], 1'b1};
                nl[kid1[p]] = nl[p] + LEN_W'(1);
            end
            for (int s = 0; s < ALPHABET; s++)
            begin
                cb[s] = nc[s];
                cl[s] = nl[s];
            end
        endfunction

        function void note_letter(logic [LTR_W-1:0] l, logic lst);
            logic [CODE_W-1:0] cb[ALPHABET];
            logic [LEN_W-1:0]  cl[ALPHABET];
            code_word_t        w;
            if (l < ALPHABET && line_ltrs.size() < LINE_MAX)
            begin
                line_ltrs.push_back(l);
                freq[l] = freq[l] + 7'(1);
            end
            if (lst && line_ltrs.size() > 0)
            begin
                build_table(cb, cl);
                foreach (line_ltrs[i])
                begin
                    w.ltr  = line_ltrs[i];
                    w.bits = cb[line_ltrs[i]];
                    w.len  = cl[line_ltrs[i]];
                    w.eol  = (i == line_ltrs.size() - 1);
                    pending.push_back(w);
                end
                line_ltrs.delete();
                foreach (freq[i]) freq[i] = '0;
            end
        endfunction

        function void check_code(code_word_t got);
            code_word_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected code word %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.ltr !== exp.ltr)
            begin
                $display("%0t: out_letter exp %0d got %0d", $time, exp.ltr, got.ltr);
                errors++;
            end
            if (got.bits !== exp.bits)
            begin
                $display("%0t: code_bits exp %h got %h", $time, exp.bits, got.bits);
                errors++;
            end
            if (got.len !== exp.len)
            begin
                $display("%0t: code_length exp %0d got %0d", $time, exp.len, got.len);
                errors++;
            end
            if (got.eol !== exp.eol)
            begin
                $display("%0t: end_of_line exp %0d got %0d", $time, exp.eol, got.eol);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             letter_valid;
    logic             letter_stall;
    logic [LTR_W-1:0] letter;
    logic             last;
    logic             code_valid;
    logic             code_stall;
    logic [LTR_W-1:0] out_letter;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0] code_length;
    logic             end_of_line;

    code_scoreboard sb;
    int             words_sent;
    int             codes_seen;
    bit             sink_calm;
    int             sink_wait;

    huffman_code_builder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_valid (letter_valid),
        .letter_stall (letter_stall),
        .letter       (letter),
        .last         (last),
        .code_valid   (code_valid),
        .code_stall   (code_stall),
        .out_letter   (out_letter),
        .code_bits    (code_bits),
        .code_length  (code_length),
        .end_of_line  (end_of_line)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // send one letter word, after a random gap unless calm is set
    task automatic send_letter(input logic [LTR_W-1:0] l, input logic lst, input bit calm);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            letter_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        letter_valid <= 1'b1;
        letter       <= l;
        last         <= lst;
        @(posedge clk);
        while (letter_stall) @(posedge clk);
        sb.note_letter(l, lst);
        words_sent++;
    endtask

    // one line of random letters from a small or full alphabet
    task automatic send_line(input int len, input int span, input bit calm);
        for (int i = 0; i < len; i++)
            send_letter(LTR_W'($urandom_range(0, span - 1)), i == len - 1, calm);
    endtask

    task automatic wait_drained();
        letter_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // code side: random wait per word unless sink_calm is set, check on accept
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            code_stall <= 1'b0;
            sink_wait  = 0;
        end
        else
        begin
            if (code_valid && !code_stall)
            begin
                sb.check_code('{out_letter, code_bits, code_length, end_of_line});
                codes_seen++;
                sink_wait = sink_calm ? 0 : $urandom_range(0, 19);
            end
            else if (code_valid && sink_wait > 0)
                sink_wait--;
            code_stall <= (sink_wait > 0);
        end
    end

    initial
    begin
        sb           = new();
        words_sent   = 0;
        codes_seen   = 0;
        sink_calm    = 1'b0;
        rst_n        = 1'b0;
        letter_valid = 1'b0;
        letter       = '0;
        last         = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single symbol, empty line, out of range, two symbols, extremes
        send_letter(5'd0, 1'b1, 1'b1);
        send_letter(5'd25, 1'b0, 1'b1);
        send_letter(5'd25, 1'b1, 1'b1);
        send_letter(5'd31, 1'b1, 1'b1);
        send_letter(5'd26, 1'b0, 1'b1);
        send_letter(5'd0, 1'b0, 1'b1);
        send_letter(5'd25, 1'b1, 1'b1);
        send_letter(5'd16, 1'b0, 1'b0);
        send_letter(5'd15, 1'b0, 1'b0);
        send_letter(5'd15, 1'b0, 1'b0);
        send_letter(5'd1, 1'b1, 1'b0);
        // sender holds off until every code word is back
        wait_drained();
        // overlong line saturates at the store depth
        sink_calm = 1'b1;
        send_line(70, 26, 1'b1);
        sink_calm = 1'b0;
        wait_drained();

        // random lines, mostly short, one full alphabet spread
        send_line(26, 26, 1'b0);
        while (words_sent < 280)
        begin
            if ($urandom_range(0, 9) == 0)
                send_letter(LTR_W'($urandom_range(26, 31)), 1'($urandom_range(0, 1)),
                            1'b0);
            else
                send_line($urandom_range(1, 12), $urandom_range(1, 26),
                          $urandom_range(0, 3) == 0);
        end
        wait_drained();

        $display("sent %0d letter words, checked %0d code words incl. saturated and",
                 words_sent, codes_seen);
        $display("single-symbol lines, with random gaps and stalls on both sides");
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire

>>> huffman_code_builder.f
+incdir+hdl
hdl/hcb_pkg.sv
hdl/hcb_ctrl.sv
hdl/hcb_datapath.sv
hdl/huffman_code_builder.sv
hdl/hcb_checker.sv
tb/huffman_code_builder_tb.sv
